FILE: rtl/spo_pkg.sv
// Shared constants, types and command/status structs of the spiral order readout.
package spo_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int ELEM_WIDTH  = 32;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RD_W   = $clog2(MAX_ROWS + 1);
    localparam int CD_W   = $clog2(MAX_COLS + 1);

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 4'd8;

    typedef struct packed {
        logic load_wr;
        logic walk_start;
        logic walk_step;
    } t_cmd;

    typedef struct packed {
        logic load_done;
        logic pipe_adv;
        logic walk_last;
    } t_sts;

endpackage

FILE: rtl/spo_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/spo_ctrl.sv
// Controller state machine: loading items, then walking the spiral.
module spo_ctrl
    import spo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid && i_sts.load_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.pipe_adv && i_sts.walk_last) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_in_ready       = (r_state == S_LOAD);
        o_cmd.load_wr    = (r_state == S_LOAD) && i_in_valid;
        o_cmd.walk_start = (r_state == S_LOAD) && i_in_valid && i_sts.load_done;
        o_cmd.walk_step  = (r_state == S_EMIT) && i_sts.pipe_adv;
    end

endmodule

FILE: rtl/spo_datapath.sv
// Datapath: configuration, load counter, element store, spiral walker and output stage.
module spo_datapath
    import spo_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic signed [ELEM_WIDTH-1:0] i_element,
    input  logic                         i_out_ready,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    output logic signed [ELEM_WIDTH-1:0] o_value,
    output logic                         o_final_res
);

    typedef enum logic [1:0] {
        L_TOP,
        L_RIGHT,
        L_BOTTOM,
        L_LEFT
    } t_leg;

    logic [CFG_W-1:0] r_row_cfg;
    logic [CFG_W-1:0] r_col_cfg;
    logic [RD_W-1:0]  rows_eff;
    logic [CD_W-1:0]  cols_eff;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] r_load_count;
    logic [CNT_W:0]   count_inc;

    t_leg            r_leg, n_leg;
    logic [RI_W-1:0] r_row, n_row, r_top, n_top, r_bot, n_bot;
    logic [CI_W-1:0] r_col, n_col, r_left, n_left, r_right, n_right;
    logic            walk_done;
    logic [ADDR_W-1:0] rd_addr;

    logic [ELEM_WIDTH-1:0] ram_rd_data;
    logic                  pipe_adv;
    logic                  r_rd_valid;
    logic                  r_rd_last;
    logic                  r_out_valid;
    logic [ELEM_WIDTH-1:0] r_out_value;
    logic                  r_out_last;

    // Configuration registers; a count of zero acts as one, above the maximum it saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cfg <= CFG_DIM_RESET;
            r_col_cfg <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT: r_row_cfg <= i_cfg_data;
                CFG_COL_COUNT: r_col_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_row_cfg == '0) begin
            rows_eff = RD_W'(1);
        end else if (32'(r_row_cfg) > MAX_ROWS) begin
            rows_eff = RD_W'(MAX_ROWS);
        end else begin
            rows_eff = RD_W'(r_row_cfg);
        end
        if (r_col_cfg == '0) begin
            cols_eff = CD_W'(1);
        end else if (32'(r_col_cfg) > MAX_COLS) begin
            cols_eff = CD_W'(MAX_COLS);
        end else begin
            cols_eff = CD_W'(r_col_cfg);
        end
    end

    assign total     = CNT_W'(int'(rows_eff) * int'(cols_eff));
    assign count_inc = {1'b0, r_load_count} + (CNT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (i_cmd.load_wr) begin
            r_load_count <= o_sts.load_done ? '0 : count_inc[CNT_W-1:0];
        end
    end

    // Spiral walker: one coordinate per step, ring bounds shrink after the left leg.
    always_comb begin
        n_leg     = r_leg;
        n_row     = r_row;
        n_col     = r_col;
        n_top     = r_top;
        n_bot     = r_bot;
        n_left    = r_left;
        n_right   = r_right;
        walk_done = 1'b0;
        unique case (r_leg)
            L_TOP: begin
                if (r_col < r_right) begin
                    n_col = r_col + CI_W'(1);
                end else if (r_row < r_bot) begin
                    n_leg = L_RIGHT;
                    n_row = r_row + RI_W'(1);
                end else begin
                    walk_done = 1'b1;
                end
            end
            L_RIGHT: begin
                if (r_row < r_bot) begin
                    n_row = r_row + RI_W'(1);
                end else if (r_left >= r_right) begin
                    walk_done = 1'b1;
                end else if ({1'b0, r_right} > {1'b0, r_left} + (CI_W+1)'(1)) begin
                    n_leg = L_BOTTOM;
                    n_col = r_right - CI_W'(1);
                end else begin
                    n_leg = L_LEFT;
                    n_col = r_left;
                end
            end
            L_BOTTOM: begin
                if ({1'b0, r_col} > {1'b0, r_left} + (CI_W+1)'(1)) begin
                    n_col = r_col - CI_W'(1);
                end else begin
                    n_leg = L_LEFT;
                    n_col = r_left;
                end
            end
            L_LEFT: begin
                if ({1'b0, r_row} > {1'b0, r_top} + (RI_W+1)'(1)) begin
                    n_row = r_row - RI_W'(1);
                end else if (({1'b0, r_top} + (RI_W+1)'(2) <= {1'b0, r_bot}) &&
                             ({1'b0, r_left} + (CI_W+1)'(2) <= {1'b0, r_right})) begin
                    n_leg   = L_TOP;
                    n_top   = r_top + RI_W'(1);
                    n_bot   = r_bot - RI_W'(1);
                    n_left  = r_left + CI_W'(1);
                    n_right = r_right - CI_W'(1);
                    n_row   = r_top + RI_W'(1);
                    n_col   = r_left + CI_W'(1);
                end else begin
                    walk_done = 1'b1;
                end
            end
            default: walk_done = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_leg   <= L_TOP;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_left  <= '0;
            r_bot   <= RI_W'(rows_eff - RD_W'(1));
            r_right <= CI_W'(cols_eff - CD_W'(1));
        end else if (i_cmd.walk_step) begin
            r_leg   <= n_leg;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign rd_addr = ADDR_W'(int'(r_row) * int'(cols_eff) + int'(r_col));

    spo_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_wr),
        .i_wr_addr (r_load_count[ADDR_W-1:0]),
        .i_wr_data (i_element),
        .i_rd_en   (i_cmd.walk_step),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Two-stage read pipeline with one stall signal: RAM read data, then output register.
    assign pipe_adv = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_adv) begin
            r_rd_valid  <= i_cmd.walk_step;
            r_out_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r_rd_last   <= walk_done;
            r_out_value <= ram_rd_data;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_sts.load_done = (count_inc >= {1'b0, total});
    assign o_sts.pipe_adv  = pipe_adv;
    assign o_sts.walk_last = walk_done;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_final_res = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count < CNT_W'(STORE_DEPTH))
        else $error("load count left the store");

    a_walk_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_row >= r_top) && (r_row <= r_bot) &&
                            (r_col >= r_left) && (r_col <= r_right))
        else $error("spiral walker outside its ring");

    a_addr_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> ({1'b0, rd_addr} < (ADDR_W+1)'(total)))
        else $error("spiral read beyond the loaded matrix");

    a_last_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_step && walk_done) |=> r_rd_valid && r_rd_last)
        else $error("last spiral read not marked");

endmodule

FILE: rtl/spiral_order_readout.sv
// Top level of the spiral order readout: handshakes, controller and datapath.
// The first result follows the completing item via emit state, RAM read and output register.
// Throughput: one item loaded per cycle, then one result per cycle while i_out_ready allows;
// the single read port of the element store sets the emission rate.
// No item is accepted from the cycle after the completing item until the last read is issued.
// Reset (synchronous, active low) empties the pipeline, zeroes the load count and sets 8x8.
module spiral_order_readout
    import spo_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // Input item channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [ELEM_WIDTH-1:0] i_element,
    // Result item channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [ELEM_WIDTH-1:0] o_value,
    output logic                         o_final_res
);

    // The controller only sequences: loading while ready is high, then one spiral step
    // each cycle that the output pipeline can move. All data storage sits in the datapath.
    t_cmd cmd;
    t_sts sts;

    spo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the element store, the load counter, the walker that produces
    // spiral coordinates and the registered output stage, which lets a finished result
    // wait for the consumer while further items are loaded.
    spo_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_element   (i_element),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_final_res (o_final_res)
    );

endmodule
